>>> rtl/core/wrem_pkg.sv
// Package: widths, constants and shared types for the relative error mean block.
`timescale 1ns / 1ps
package wrem_pkg;
    localparam int DEF_NUM_BINS = 16;
    localparam logic [15:0] WEIGHT_ONE = 16'd256;
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] ref_sample;
        logic [15:0] sim_sample;
        logic [16:0] aniso_value;
        logic        in_mask;
        logic        last_sample;
        logic [3:0]  bin_index;
        logic [15:0] bin_weight;
    } t_in_req;

    typedef struct packed {
        logic [31:0] mean_error;
        logic [31:0] sample_total;
        logic        no_valid_samples;
    } t_out_req;

    // front -> back queue entry
    typedef struct packed {
        logic        count;
        logic        last;
        logic [15:0] ad;
        logic [14:0] refv;
        logic [31:0] w2;
        logic        weighted;
    } t_job;
endpackage

>>> rtl/core/wrem_if.sv
// Valid/ready stream interfaces for input and result requests.
`timescale 1ns / 1ps
interface wrem_in_if import wrem_pkg::*; ();
    logic    valid;
    logic    ready;
    t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wrem_out_if import wrem_pkg::*; ();
    logic     valid;
    logic     ready;
    t_out_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/wrem_front.sv
// Front end: weight table, sample classification, job queue.
`timescale 1ns / 1ps
module wrem_front import wrem_pkg::*; #(
    parameter int NUM_BINS = DEF_NUM_BINS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_weight,
    wrem_in_if.sink    s_in,
    output logic       o_job_valid,
    output t_job       o_job,
    input  logic       i_job_pop
);
    localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int DEPTH = 2;

    logic [15:0] r_tab [NUM_BINS];
    logic [NUM_BINS-1:0] r_tab_vld;
    t_job r_q [DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job r_s_job;
    logic r_s_vld;
    logic [15:0] r_s_w;

    t_in_req d;
    logic signed [15:0] rs, ss;
    logic signed [16:0] diff;
    logic [16:0] adf;
    logic [BW+16:0] prod;
    logic [BW-1:0] bin;
    logic cnt_ok;
    t_job job, q_job;
    logic take;

    assign d = s_in.data;
    assign rs = d.ref_sample;
    assign ss = d.sim_sample;
    // stage plus queue hold at most DEPTH requests
    assign s_in.ready = ((r_cnt + 2'(r_s_vld)) < 2'(DEPTH));
    assign take = s_in.valid && s_in.ready && d.func == FUNC_SAMPLE;

    always_comb begin
        diff = 17'(ss) - 17'(rs);
        adf = diff[16] ? 17'(-diff) : 17'(diff);
        prod = (BW+17)'(d.aniso_value) * (BW+17)'(NUM_BINS);
        if (prod[BW+16:16] > (BW+1)'(NUM_BINS - 1)) begin
            bin = BW'(NUM_BINS - 1);
        end else begin
            bin = prod[BW+15:16];
        end
        cnt_ok = d.in_mask && !rs[15] && (rs != 16'sd0)
                 && (!i_cfg_weight || d.aniso_value != 17'd0);
        job.count = cnt_ok;
        job.last = d.last_sample;
        job.ad = adf[15:0];
        job.refv = d.ref_sample[14:0];
        job.w2 = '0;
        job.weighted = i_cfg_weight;
    end

    always_comb begin
        q_job = r_s_job;
        q_job.w2 = 32'(r_s_w) * 32'(r_s_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_vld <= '0;
        end else if (s_in.valid && s_in.ready && d.func == FUNC_LOAD
                     && 32'(d.bin_index) < NUM_BINS) begin
            r_tab_vld[BW'(d.bin_index)] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready && d.func == FUNC_LOAD
            && 32'(d.bin_index) < NUM_BINS) begin
            r_tab[BW'(d.bin_index)] <= d.bin_weight;
        end
        if (take) begin
            r_s_job <= job;
            r_s_w <= r_tab_vld[bin] ? r_tab[bin] : WEIGHT_ONE;
        end
        if (r_s_vld) begin
            r_q[r_wp] <= q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_s_vld <= take;
            if (r_s_vld) r_wp <= ~r_wp;
            if (i_job_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(r_s_vld) - 2'(i_job_pop);
        end
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];
endmodule

>>> rtl/core/wrem_back.sv
// Back end: serial divide, w^4 scaling, accumulation and final mean.
`timescale 1ns / 1ps
module wrem_back import wrem_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    wrem_out_if.source m_out
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_M1   = 3'd2;
    localparam logic [2:0] ST_M2   = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_MEAN = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] r_st;
    logic [6:0] r_it;
    t_job r_job;
    logic [63:0] r_acc, r_num;
    logic [31:0] r_cnt, r_div;
    logic [32:0] r_rem;
    logic [63:0] r_p, r_hi, r_lo;
    logic r_ovf;
    t_out_req r_out;
    logic r_ov;

    logic [32:0] trial;
    logic [64:0] sum;
    logic [64:0] hl;

    assign o_job_pop = (r_st == ST_IDLE) && i_job_valid;
    assign m_out.valid = r_ov;
    assign m_out.data = r_out;
    assign trial = {r_rem[31:0], r_num[63]};
    assign sum = {1'b0, r_acc} + {1'b0, r_lo};
    assign hl = {1'b0, r_hi} + {33'd0, r_p[63:32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_acc <= '0;
            r_cnt <= '0;
            r_ov <= 1'b0;
        end else begin
            if (m_out.valid && m_out.ready && r_st != ST_OUT) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    if (i_job.count) begin
                        r_num <= {i_job.ad, 48'd0};
                        r_div <= {17'd0, i_job.refv};
                        r_rem <= '0;
                        r_it <= 7'd32;
                        r_st <= ST_DIV;
                    end else begin
                        r_st <= i_job.last ? ST_MEAN : ST_IDLE;
                        r_it <= 7'd64;
                        r_num <= r_acc;
                        r_div <= r_cnt;
                        r_rem <= '0;
                    end
                end
                ST_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (trial >= {1'b0, r_div}) begin
                        r_rem <= trial - {1'b0, r_div};
                        r_num <= {r_num[62:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_num <= {r_num[62:0], 1'b0};
                    end
                    r_it <= r_it - 7'd1;
                    if (r_it == 7'd1) r_st <= r_job.weighted ? ST_M1 : ST_ACC;
                end
                ST_M1: begin
                    r_p <= 64'(r_num[31:0]) * 64'(r_job.w2);
                    r_lo <= {32'd0, r_num[31:0]};
                    r_st <= ST_M2;
                end
                ST_M2: begin
                    r_hi <= 64'(r_p[63:32]) * 64'(r_job.w2);
                    r_p <= {32'd0, r_p[31:0]} * 64'(r_job.w2);
                    r_lo <= '0;
                    r_st <= ST_ACC;
                    r_ovf <= 1'b1;
                end
                ST_ACC: begin
                    if (r_job.weighted && r_ovf) begin
                        r_lo <= hl[64] ? '1 : hl[63:0];
                        r_ovf <= 1'b0;
                    end else if (!r_job.weighted) begin
                        r_lo <= {32'd0, r_num[31:0]};
                        r_job.weighted <= 1'b1;
                        r_ovf <= 1'b0;
                    end else begin
                        r_acc <= sum[64] ? '1 : sum[63:0];
                        r_cnt <= (r_cnt == '1) ? r_cnt : r_cnt + 32'd1;
                        r_num <= sum[64] ? '1 : sum[63:0];
                        r_div <= (r_cnt == '1) ? r_cnt : r_cnt + 32'd1;
                        r_rem <= '0;
                        r_it <= 7'd64;
                        r_st <= r_job.last ? ST_MEAN : ST_IDLE;
                    end
                end
                ST_MEAN: begin
                    if (r_div == '0) begin
                        r_it <= 7'd0;
                        r_st <= ST_OUT;
                    end else begin
                        if (trial >= {1'b0, r_div}) begin
                            r_rem <= trial - {1'b0, r_div};
                            r_num <= {r_num[62:0], 1'b1};
                        end else begin
                            r_rem <= trial;
                            r_num <= {r_num[62:0], 1'b0};
                        end
                        r_it <= r_it - 7'd1;
                        if (r_it == 7'd1) r_st <= ST_OUT;
                    end
                end
                ST_OUT: if (!r_ov || m_out.ready) begin
                    r_out.no_valid_samples <= (r_div == '0);
                    r_out.sample_total <= r_div;
                    r_out.mean_error <= (r_div == '0) ? 32'd0 :
                        ((r_num[63:32] != 32'd0) ? 32'hFFFF_FFFF : r_num[31:0]);
                    r_ov <= 1'b1;
                    r_acc <= '0;
                    r_cnt <= '0;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/weighted_relative_error_mean.sv
// Top level of the weighted mean absolute relative error block.
//  channel  dir  contents
//  s_in     in   sample or weight-load request
//  m_out    out  mean, count, empty flag
//  cfg      in   weight_by_anisotropy write
// A sample passes through the front stage (registered weight read), then a
// two-entry queue; input stalls while stage and queue hold two requests.
// Back end: counted samples run the bit-serial divider, the multiply states if
// weighted, then accumulation; uncounted samples are only popped and loads
// never reach it. A last sample then runs the mean divide and the output
// state. Reset is synchronous; the weight table reads 1.0 until loaded.
`timescale 1ns / 1ps
module weighted_relative_error_mean import wrem_pkg::*; #(
    parameter int NUM_BINS = DEF_NUM_BINS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    wrem_in_if.sink     s_in,
    wrem_out_if.source  m_out
);
    logic r_weight;
    logic job_valid, job_pop;
    t_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= 1'b0;
        end else if (i_cfg_we) begin
            r_weight <= i_cfg_wdata;
        end
    end

    wrem_front #(.NUM_BINS(NUM_BINS)) u_front (
        .i_clk, .i_rst_n, .i_cfg_weight(r_weight), .s_in,
        .o_job_valid(job_valid), .o_job(job), .i_job_pop(job_pop)
    );

    wrem_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .i_job(job),
        .o_job_pop(job_pop), .m_out
    );
endmodule

>>> rtl/core/wrem_checker.sv
// Port-level checker for the top level, with bind.
`timescale 1ns / 1ps
module wrem_port_checks import wrem_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input t_out_req out_data
);
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.no_valid_samples |-> out_data.mean_error == 32'd0
            && out_data.sample_total == 32'd0)
        else $error("empty result not zero");
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.sample_total == 32'd0 |-> out_data.no_valid_samples)
        else $error("zero count without flag");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
endmodule

bind weighted_relative_error_mean wrem_port_checks u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .out_valid(m_out.valid),
    .out_ready(m_out.ready), .out_data(m_out.data)
);
